// File: sv/dtte_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtte_pkg
// Shared types and constants of the timestamp text to epoch converter.
// ----------------------------------------------------------------------------
package dtte_pkg;

  localparam logic [7:0] CH_DASH  = 8'h2D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  localparam logic [4:0] POS_MIN_LEN  = 5'd19;
  localparam logic [4:0] POS_FRAC_END = 5'd23;

  localparam logic [13:0] YEAR_MIN   = 14'd1970;
  localparam logic [12:0] ERA_RECIP  = 13'd5243;
  localparam int          ERA_SHIFT  = 21;
  localparam logic [5:0]  C100_RECIP = 6'd41;
  localparam int          C100_SHIFT = 12;
  localparam logic [8:0]  YEAR_LEN   = 9'd365;
  localparam logic [8:0]  ERA_YEARS  = 9'd400;
  localparam logic [17:0] ERA_DAYS   = 18'd146097;
  localparam logic [22:0] EPOCH_DAYS = 23'd719468;
  localparam logic [16:0] DAY_SECS   = 17'd86400;
  localparam logic [11:0] HOUR_SECS  = 12'd3600;

  localparam int TS_W = 48;

  typedef struct packed {
    logic        ok;
    logic        ms_mode;
    logic [13:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
    logic [9:0]  frac;
  } dtte_rec_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_ERA,
    BK_YOE,
    BK_DOE,
    BK_DAYS,
    BK_SEC,
    BK_MS,
    BK_OUT
  } bk_state_e;

  typedef struct packed {
    logic pop;
    logic out_load;
  } bk_ctrl_t;

  // Days from March 1 to the first of the shifted month.
  function automatic logic [8:0] month_offset(input logic [3:0] mp);
    logic [8:0] r;
    r = 9'd0;
    case (mp)
      4'd0:    r = 9'd0;
      4'd1:    r = 9'd31;
      4'd2:    r = 9'd61;
      4'd3:    r = 9'd92;
      4'd4:    r = 9'd122;
      4'd5:    r = 9'd153;
      4'd6:    r = 9'd184;
      4'd7:    r = 9'd214;
      4'd8:    r = 9'd245;
      4'd9:    r = 9'd275;
      4'd10:   r = 9'd306;
      4'd11:   r = 9'd337;
      default: r = 9'd0;
    endcase
    return r;
  endfunction

endpackage

// File: sv/datetime_text_to_epoch_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// datetime_text_to_epoch_top
// Timestamp line to Unix time: parser, record queue and epoch converter.
// ----------------------------------------------------------------------------
// Throughput: one character per cycle while the record queue has room.
// Each queued record passes the era, year, day, seconds and ms steps into the
// output beat; the sequencer takes one record at a time, bounding line rate.
// Reset: asynchronous, clears parser state, queue, sequencer, output valid
// and the milliseconds mode register.
module datetime_text_to_epoch_top #(
  parameter int FifoDepth = 2
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] ch
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,   // [47:0] timestamp
  output logic        m_axis_tuser,   // [0] valid_res
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import dtte_pkg::*;

  logic      ms_mode_q;
  logic      push, pop, full, empty;
  dtte_rec_t rec_in, rec_out;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == 1'b0) ? {31'd0, ms_mode_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ms_mode_q <= 1'b0;
    end else if (psel && penable && pwrite && pready && (paddr[2] == 1'b0)) begin
      ms_mode_q <= pwdata[0];
    end
  end

  assign s_axis_tready = ~full;

  dtte_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_i (s_axis_tready),
    .ch_i       (s_axis_tdata),
    .last_i     (s_axis_tlast),
    .ms_mode_i  (ms_mode_q),
    .push_o     (push),
    .rec_o      (rec_in)
  );

  dtte_fifo #(
    .Depth (FifoDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (rec_in),
    .pop_i   (pop),
    .rdata_o (rec_out),
    .full_o  (full),
    .empty_o (empty)
  );

  dtte_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .empty_i     (empty),
    .rec_i       (rec_out),
    .pop_o       (pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_ok_o    (m_axis_tuser),
    .out_ts_o    (m_axis_tdata)
  );

endmodule

// File: sv/dtte_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtte_front
// Character parser: checks separators and digits by position, accumulates
// the date and time fields and pushes one record per line.
// ----------------------------------------------------------------------------
module dtte_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_ready_i,
  input  logic [7:0]         ch_i,
  input  logic               last_i,
  input  logic               ms_mode_i,
  output logic               push_o,
  output dtte_pkg::dtte_rec_t rec_o
);
  import dtte_pkg::*;

  logic [4:0]  position_q, position_d, pos_u;
  logic [13:0] year_q, year_d, year_u;
  logic [6:0]  month_q, month_d, month_u;
  logic [6:0]  day_q, day_d, day_u;
  logic [6:0]  hour_q, hour_d, hour_u;
  logic [6:0]  minute_q, minute_d, minute_u;
  logic [6:0]  second_q, second_d, second_u;
  logic [9:0]  frac_q, frac_d, frac_u;
  logic        err_q, err_d, err_u;
  logic        frac_ok_q, frac_ok_d, frac_ok_u;
  logic        accept, is_dig;
  logic [3:0]  dig;

  assign accept = in_valid_i & in_ready_i;
  assign is_dig = (ch_i >= CH_ZERO) && (ch_i <= CH_NINE);
  assign dig    = ch_i[3:0];

  always_comb begin
    pos_u     = position_q;
    year_u    = year_q;
    month_u   = month_q;
    day_u     = day_q;
    hour_u    = hour_q;
    minute_u  = minute_q;
    second_u  = second_q;
    frac_u    = frac_q;
    err_u     = err_q;
    frac_ok_u = frac_ok_q;
    case (position_q) inside
      5'd4, 5'd7:   if (ch_i != CH_DASH) err_u = 1'b1;
      5'd10:        if (ch_i != CH_SPACE) err_u = 1'b1;
      5'd13, 5'd16: if (ch_i != CH_COLON) err_u = 1'b1;
      [5'd0:5'd3]: begin
        if (!is_dig) err_u = 1'b1;
        else year_u = 14'(year_q * 14'd10 + 14'(dig));
      end
      [5'd5:5'd6]: begin
        if (!is_dig) err_u = 1'b1;
        else month_u = 7'(month_q * 7'd10 + 7'(dig));
      end
      [5'd8:5'd9]: begin
        if (!is_dig) err_u = 1'b1;
        else day_u = 7'(day_q * 7'd10 + 7'(dig));
      end
      [5'd11:5'd12]: begin
        if (!is_dig) err_u = 1'b1;
        else hour_u = 7'(hour_q * 7'd10 + 7'(dig));
      end
      [5'd14:5'd15]: begin
        if (!is_dig) err_u = 1'b1;
        else minute_u = 7'(minute_q * 7'd10 + 7'(dig));
      end
      [5'd17:5'd18]: begin
        if (!is_dig) err_u = 1'b1;
        else second_u = 7'(second_q * 7'd10 + 7'(dig));
      end
      5'd19:        if (ch_i != CH_DOT) frac_ok_u = 1'b0;
      [5'd20:5'd22]: begin
        if (is_dig) frac_u = 10'(frac_q * 10'd10 + 10'(dig));
        else frac_ok_u = 1'b0;
      end
      default: ;
    endcase
    if (position_q < POS_FRAC_END) pos_u = position_q + 5'd1;
  end

  assign push_o = accept & last_i;

  always_comb begin
    rec_o.ok = (pos_u >= POS_MIN_LEN) && !err_u &&
               (month_u >= 7'd1) && (month_u <= 7'd12) &&
               (day_u >= 7'd1) && (day_u <= 7'd31) &&
               (hour_u <= 7'd23) && (minute_u <= 7'd59) && (second_u <= 7'd59) &&
               (year_u >= YEAR_MIN);
    rec_o.ms_mode = ms_mode_i;
    rec_o.year    = year_u;
    rec_o.month   = month_u[3:0];
    rec_o.day     = day_u[4:0];
    rec_o.hour    = hour_u[4:0];
    rec_o.minute  = minute_u[5:0];
    rec_o.second  = second_u[5:0];
    rec_o.frac    = ((pos_u >= POS_FRAC_END) && frac_ok_u) ? frac_u : 10'd0;
  end

  always_comb begin
    position_d = position_q;
    year_d     = year_q;
    month_d    = month_q;
    day_d      = day_q;
    hour_d     = hour_q;
    minute_d   = minute_q;
    second_d   = second_q;
    frac_d     = frac_q;
    err_d      = err_q;
    frac_ok_d  = frac_ok_q;
    if (push_o) begin
      position_d = '0;
      year_d     = '0;
      month_d    = '0;
      day_d      = '0;
      hour_d     = '0;
      minute_d   = '0;
      second_d   = '0;
      frac_d     = '0;
      err_d      = 1'b0;
      frac_ok_d  = 1'b1;
    end else if (accept) begin
      position_d = pos_u;
      year_d     = year_u;
      month_d    = month_u;
      day_d      = day_u;
      hour_d     = hour_u;
      minute_d   = minute_u;
      second_d   = second_u;
      frac_d     = frac_u;
      err_d      = err_u;
      frac_ok_d  = frac_ok_u;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      position_q <= '0;
      year_q     <= '0;
      month_q    <= '0;
      day_q      <= '0;
      hour_q     <= '0;
      minute_q   <= '0;
      second_q   <= '0;
      frac_q     <= '0;
      err_q      <= 1'b0;
      frac_ok_q  <= 1'b1;
    end else begin
      position_q <= position_d;
      year_q     <= year_d;
      month_q    <= month_d;
      day_q      <= day_d;
      hour_q     <= hour_d;
      minute_q   <= minute_d;
      second_q   <= second_d;
      frac_q     <= frac_d;
      err_q      <= err_d;
      frac_ok_q  <= frac_ok_d;
    end
  end

endmodule

// File: sv/dtte_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtte_fifo
// Short record queue between the parser and the epoch converter.
// ----------------------------------------------------------------------------
module dtte_fifo #(
  parameter int Depth = 2
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  dtte_pkg::dtte_rec_t wdata_i,
  input  logic                pop_i,
  output dtte_pkg::dtte_rec_t rdata_o,
  output logic                full_o,
  output logic                empty_o
);
  import dtte_pkg::*;

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  dtte_rec_t           mem_q [Depth];
  logic [PtrW-1:0]     wptr_q, wptr_d, rptr_q, rptr_d;
  logic [CntW-1:0]     cnt_q, cnt_d;
  logic                do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & ~empty_o;
  assign rdata_o = mem_q[rptr_q];

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (do_push) wptr_d = (wptr_q == PtrW'(Depth - 1)) ? '0 : wptr_q + PtrW'(1);
    if (do_pop)  rptr_d = (rptr_q == PtrW'(Depth - 1)) ? '0 : rptr_q + PtrW'(1);
    if (do_push && !do_pop)      cnt_d = cnt_q + CntW'(1);
    else if (do_pop && !do_push) cnt_d = cnt_q - CntW'(1);
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wptr_q] <= wdata_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

endmodule

// File: sv/dtte_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtte_back
// Epoch converter: civil date to day count, then seconds or milliseconds,
// one step per cycle, into a registered output beat that waits out a stall.
// ----------------------------------------------------------------------------
module dtte_back (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      empty_i,
  input  dtte_pkg::dtte_rec_t       rec_i,
  output logic                      pop_o,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic                      out_ok_o,
  output logic [dtte_pkg::TS_W-1:0] out_ts_o
);
  import dtte_pkg::*;

  bk_state_e       state_q, state_d;
  bk_ctrl_t        ctrl;
  dtte_rec_t       rec_q;
  logic [13:0]     y_q;
  logic [3:0]      mp_q;
  logic [4:0]      era_q;
  logic [8:0]      yoe_q;
  logic [16:0]     hms_q;
  logic [17:0]     doe_q;
  logic [21:0]     eraterm_q;
  logic [21:0]     days_q;
  logic [37:0]     sec_q;
  logic [TS_W-1:0] ts_q;
  logic            out_valid_q;
  logic            out_ok_q;
  logic [TS_W-1:0] out_ts_q;
  logic            out_free;

  logic [26:0]     era_prod;
  logic [13:0]     y_c;
  logic [13:0]     era_x400;
  logic [14:0]     c100_prod;
  logic [17:0]     doe_c;
  logic [22:0]     days_c;
  logic [TS_W-1:0] ms_c;

  assign out_free = ~out_valid_q | out_ready_i;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      BK_IDLE: if (!empty_i) state_d = BK_ERA;
      BK_ERA:  state_d = BK_YOE;
      BK_YOE:  state_d = BK_DOE;
      BK_DOE:  state_d = BK_DAYS;
      BK_DAYS: state_d = BK_SEC;
      BK_SEC:  state_d = BK_MS;
      BK_MS:   state_d = BK_OUT;
      BK_OUT:  if (out_free) state_d = BK_IDLE;
      default: state_d = BK_IDLE;
    endcase
  end

  always_comb begin
    ctrl = '0;
    unique case (state_q)
      BK_IDLE: ctrl.pop = ~empty_i;
      BK_OUT:  ctrl.out_load = out_free;
      default: ctrl = '0;
    endcase
  end

  assign pop_o = ctrl.pop;

  assign y_c       = rec_i.year - ((rec_i.month <= 4'd2) ? 14'd1 : 14'd0);
  assign era_prod  = 27'(y_q) * 27'(ERA_RECIP);
  assign era_x400  = 14'(era_q) * 14'(ERA_YEARS);
  assign c100_prod = 15'(yoe_q) * 15'(C100_RECIP);
  assign doe_c     = 18'(yoe_q) * 18'(YEAR_LEN) + 18'(yoe_q >> 2)
                   - 18'(c100_prod >> C100_SHIFT)
                   + 18'(month_offset(mp_q)) + 18'(rec_q.day) - 18'd1;
  assign days_c    = 23'(eraterm_q) + 23'(doe_q) - EPOCH_DAYS;
  assign ms_c      = (TS_W'(sec_q) << 10) - (TS_W'(sec_q) << 4) - (TS_W'(sec_q) << 3)
                   + TS_W'(rec_q.frac);

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      BK_IDLE: begin
        rec_q <= rec_i;
        y_q   <= y_c;
        mp_q  <= (rec_i.month > 4'd2) ? rec_i.month - 4'd3 : rec_i.month + 4'd9;
      end
      BK_ERA: begin
        era_q <= 5'(era_prod >> ERA_SHIFT);
        hms_q <= 17'(rec_q.hour) * 17'(HOUR_SECS);
      end
      BK_YOE: begin
        yoe_q <= 9'(y_q - era_x400);
        hms_q <= hms_q + 17'(rec_q.minute) * 17'd60 + 17'(rec_q.second);
      end
      BK_DOE: begin
        doe_q     <= doe_c;
        eraterm_q <= 22'(era_q) * 22'(ERA_DAYS);
      end
      BK_DAYS: days_q <= days_c[21:0];
      BK_SEC:  sec_q  <= 38'(39'(days_q) * 39'(DAY_SECS) + 39'(hms_q));
      BK_MS:   ts_q   <= rec_q.ms_mode ? ms_c : TS_W'(sec_q);
      BK_OUT: begin
        if (ctrl.out_load) begin
          out_ok_q <= rec_q.ok;
          out_ts_q <= rec_q.ok ? ts_q : '0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (ctrl.out_load)    out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_ok_o    = out_ok_q;
  assign out_ts_o    = out_ts_q;

endmodule

// File: sv/dtte_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtte_checker
// Port-level checks of the timestamp converter, bound to the top level.
// ----------------------------------------------------------------------------
module dtte_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [47:0] m_axis_tdata,
  input logic        m_axis_tuser,
  input logic        pready
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output beat dropped or changed while stalled");

  a_invalid_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata == 48'd0)
    else $error("invalid line carries a nonzero timestamp");

  a_ts_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata <= 48'd253402300799999)
    else $error("timestamp beyond year 9999");

  a_pready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pready)
    else $error("config port not ready");

endmodule

bind datetime_text_to_epoch_top dtte_checker u_dtte_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .pready        (pready)
);
